// ===== rtl/dtfb_pkg.sv =====
// Package for the dirty-tracking frame buffer: field widths, command, status
// and internal operation codes, and the structs passed between the sub-blocks.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package dtfb_pkg;

	// Fixed field widths of the command and result transactions.
	localparam int CMD_W      = 3;
	localparam int COORD_W    = 9;
	localparam int COLOR_W    = 16;
	localparam int STATUS_W   = 2;
	localparam int EDGE_OUT_W = 8;
	localparam int COUNT_W    = 32;
	localparam int OP_W       = 3;

	// Default geometry of the frame and of one flush stripe.
	localparam int WIDTH_DEF       = 240;
	localparam int HEIGHT_DEF      = 240;
	localparam int STRIPE_ROWS_DEF = 16;

	// Entries in the queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Command codes as they arrive on the request channel.
	localparam logic [CMD_W-1:0] CMD_WRITE_IF_CHANGED = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_ALWAYS     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_READ             = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FLUSH_BEGIN      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH_STEP       = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FLUSH_ABORT      = 3'd5;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INVALID_ARG   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID_STATE = 2'd2;

	// Operations after classification by the front.
	localparam logic [OP_W-1:0] OP_WR_CMP = 3'd0;
	localparam logic [OP_W-1:0] OP_WR_ALL = 3'd1;
	localparam logic [OP_W-1:0] OP_READ   = 3'd2;
	localparam logic [OP_W-1:0] OP_BEGIN  = 3'd3;
	localparam logic [OP_W-1:0] OP_STEP   = 3'd4;
	localparam logic [OP_W-1:0] OP_ABORT  = 3'd5;
	localparam logic [OP_W-1:0] OP_BADARG = 3'd6;

	// A classified command as it waits in the queue (address travels beside it).
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
	} item_t;

	// One result transaction.
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [COLOR_W-1:0]    read_color;
		logic                  flush_done;
		logic                  window_valid;
		logic [EDGE_OUT_W-1:0] window_left;
		logic [EDGE_OUT_W-1:0] window_top;
		logic [EDGE_OUT_W-1:0] window_right;
		logic [EDGE_OUT_W-1:0] window_bottom;
		logic                  buffer_select;
		logic [COUNT_W-1:0]    commit_count;
	} result_t;

	// Status from the back to the front.
	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

// ===== rtl/dtfb_if.sv =====
// Channel interfaces of the dirty-tracking frame buffer: the command request
// and the result response, each with valid/ready and its payload.
// Depends on dtfb_pkg for the field widths.
interface dtfb_req_if;
	logic                            valid;
	logic                            ready;
	logic [dtfb_pkg::CMD_W-1:0]      cmd;
	logic [dtfb_pkg::COORD_W-1:0]    pixel_x;
	logic [dtfb_pkg::COORD_W-1:0]    pixel_y;
	logic [dtfb_pkg::COLOR_W-1:0]    pixel_color;

	modport source (output valid, cmd, pixel_x, pixel_y, pixel_color, input ready);
	modport sink (input valid, cmd, pixel_x, pixel_y, pixel_color, output ready);
endinterface

interface dtfb_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dtfb_pkg::STATUS_W-1:0]    status;
	logic [dtfb_pkg::COLOR_W-1:0]     read_color;
	logic                             flush_done;
	logic                             window_valid;
	logic [dtfb_pkg::EDGE_OUT_W-1:0]  window_left;
	logic [dtfb_pkg::EDGE_OUT_W-1:0]  window_top;
	logic [dtfb_pkg::EDGE_OUT_W-1:0]  window_right;
	logic [dtfb_pkg::EDGE_OUT_W-1:0]  window_bottom;
	logic                             buffer_select;
	logic [dtfb_pkg::COUNT_W-1:0]     commit_count;

	modport source (output valid, status, read_color, flush_done, window_valid, window_left,
		window_top, window_right, window_bottom, buffer_select, commit_count, input ready);
	modport sink (input valid, status, read_color, flush_done, window_valid, window_left,
		window_top, window_right, window_bottom, buffer_select, commit_count, output ready);
endinterface

// ===== rtl/dtfb_front.sv =====
// Front of the frame buffer: accepts command transactions, checks coordinates,
// decodes the command and forms the linear pixel address for the queue.
// Depends on dtfb_pkg and dtfb_req_if.
module dtfb_front #(
	parameter int WIDTH  = dtfb_pkg::WIDTH_DEF,
	parameter int HEIGHT = dtfb_pkg::HEIGHT_DEF,
	localparam int DEPTH  = WIDTH * HEIGHT,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	dtfb_req_if.sink                req,
	input  dtfb_pkg::back_status_t  stat,
	input  logic                    queue_full,
	output logic                    push,
	output dtfb_pkg::item_t         item,
	output logic [ADDR_W-1:0]       addr
);

	localparam int PROD_W = 2 * dtfb_pkg::COORD_W + 1;

	logic              in_range;
	logic [PROD_W-1:0] lin;

	assign req.ready = !queue_full && !stat.clearing;
	assign push      = req.valid && req.ready;

	assign in_range = (req.pixel_x < dtfb_pkg::COORD_W'(WIDTH))
		&& (req.pixel_y < dtfb_pkg::COORD_W'(HEIGHT));

	// Row-major address; only meaningful for in-range coordinates.
	assign lin  = PROD_W'(req.pixel_y) * PROD_W'(WIDTH) + PROD_W'(req.pixel_x);
	assign addr = lin[ADDR_W-1:0];

	always_comb begin
		item.x     = req.pixel_x;
		item.y     = req.pixel_y;
		item.color = req.pixel_color;
		unique case (req.cmd)
			dtfb_pkg::CMD_WRITE_IF_CHANGED: begin
				item.op = in_range ? dtfb_pkg::OP_WR_CMP : dtfb_pkg::OP_BADARG;
			end
			dtfb_pkg::CMD_WRITE_ALWAYS: begin
				item.op = in_range ? dtfb_pkg::OP_WR_ALL : dtfb_pkg::OP_BADARG;
			end
			dtfb_pkg::CMD_READ: begin
				item.op = in_range ? dtfb_pkg::OP_READ : dtfb_pkg::OP_BADARG;
			end
			dtfb_pkg::CMD_FLUSH_BEGIN: begin
				item.op = dtfb_pkg::OP_BEGIN;
			end
			dtfb_pkg::CMD_FLUSH_STEP: begin
				item.op = dtfb_pkg::OP_STEP;
			end
			dtfb_pkg::CMD_FLUSH_ABORT: begin
				item.op = dtfb_pkg::OP_ABORT;
			end
			default: begin
				item.op = dtfb_pkg::OP_BADARG;
			end
		endcase
	end

endmodule

// ===== rtl/dtfb_queue.sv =====
// Short FIFO between the front and the back of the frame buffer.
// Depends on dtfb_pkg for its depth.
module dtfb_queue #(
	parameter int DATA_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	localparam int DEPTH = dtfb_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/dtfb_back.sv =====
// Back of the frame buffer: pixel store with compare-on-write, dirty box,
// stripe flush planner, commit counter and the result register.
// Depends on dtfb_pkg and dtfb_rsp_if.
module dtfb_back #(
	parameter int WIDTH       = dtfb_pkg::WIDTH_DEF,
	parameter int HEIGHT      = dtfb_pkg::HEIGHT_DEF,
	parameter int STRIPE_ROWS = dtfb_pkg::STRIPE_ROWS_DEF,
	localparam int DEPTH  = WIDTH * HEIGHT,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    head_valid,
	input  dtfb_pkg::item_t         head_item,
	input  logic [ADDR_W-1:0]       head_addr,
	output logic                    pop,
	output dtfb_pkg::back_status_t  stat,
	dtfb_rsp_if.source              rsp
);

	localparam int CW = dtfb_pkg::COORD_W;
	localparam int EW = dtfb_pkg::EDGE_OUT_W;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_MEM   = 2'd2;

	logic [1:0] state_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [dtfb_pkg::COLOR_W-1:0] frame_mem [DEPTH];
	logic [dtfb_pkg::COLOR_W-1:0] rd_data_q;
	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_wa;
	logic [dtfb_pkg::COLOR_W-1:0] mem_wd;

	// Command held during the read-modify-write cycle.
	logic [dtfb_pkg::OP_W-1:0]    op_s1;
	logic [CW-1:0]                x_s1;
	logic [CW-1:0]                y_s1;
	logic [dtfb_pkg::COLOR_W-1:0] color_s1;
	logic [ADDR_W-1:0]            addr_s1;

	logic          dirty_valid_q;
	logic [CW-1:0] dleft_q, dtop_q, dright_q, dbottom_q;
	logic          flush_active_q;
	logic [CW-1:0] fleft_q, fright_q, frow_q, fend_q;
	logic          stripe_buf_q;
	logic [dtfb_pkg::COUNT_W-1:0] commit_q;

	dtfb_pkg::result_t res_q;
	logic              out_valid_q;

	logic              is_mem;
	logic              out_free;
	logic              adv_en;
	logic              adv_done;
	logic [CW-1:0]     src_left, src_right, src_row, src_end;
	logic              src_buf;
	logic [CW-1:0]     r_up, r_even, rem, lines, row_nxt;
	logic              wr_hit;
	dtfb_pkg::result_t res_run;
	dtfb_pkg::result_t res_mem;

	assign stat.clearing = (state_q == ST_CLEAR);

	assign is_mem = (head_item.op == dtfb_pkg::OP_WR_CMP)
		|| (head_item.op == dtfb_pkg::OP_WR_ALL)
		|| (head_item.op == dtfb_pkg::OP_READ);
	assign out_free = !out_valid_q || rsp.ready;
	assign pop      = (state_q == ST_RUN) && head_valid && out_free;

	// Pixel store: one write port, one registered read port.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_s1;
		mem_wd = color_s1;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = '0;
		end else if (state_q == ST_MEM) begin
			mem_we = wr_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= frame_mem[head_addr];
	end

	assign wr_hit = (op_s1 == dtfb_pkg::OP_WR_ALL)
		|| ((op_s1 == dtfb_pkg::OP_WR_CMP) && (rd_data_q != color_s1));

	// Stripe planner: a begin plans from the widened dirty box, a step from
	// the stored flush position.
	assign r_up   = dright_q + CW'(1);
	assign r_even = {r_up[CW-1:1], 1'b0};

	always_comb begin
		if (head_item.op == dtfb_pkg::OP_BEGIN) begin
			src_left  = {dleft_q[CW-1:1], 1'b0};
			src_right = (r_even > CW'(WIDTH)) ? CW'(WIDTH) : r_even;
			src_row   = dtop_q;
			src_end   = dbottom_q;
			src_buf   = 1'b0;
		end else begin
			src_left  = fleft_q;
			src_right = fright_q;
			src_row   = frow_q;
			src_end   = fend_q;
			src_buf   = stripe_buf_q;
		end
	end

	assign adv_done = (src_row >= src_end);
	assign rem      = src_end - src_row;
	assign lines    = (rem > CW'(STRIPE_ROWS)) ? CW'(STRIPE_ROWS) : rem;
	assign row_nxt  = src_row + lines;

	always_comb begin
		res_run = '0;
		adv_en  = 1'b0;
		unique case (head_item.op) inside
			dtfb_pkg::OP_BEGIN: begin
				if (flush_active_q) begin
					res_run.status = dtfb_pkg::STATUS_INVALID_STATE;
				end else if (!dirty_valid_q) begin
					res_run.flush_done = 1'b1;
				end else begin
					adv_en = 1'b1;
				end
			end
			dtfb_pkg::OP_STEP: begin
				if (!flush_active_q) begin
					res_run.status = dtfb_pkg::STATUS_INVALID_STATE;
				end else begin
					adv_en = 1'b1;
				end
			end
			dtfb_pkg::OP_ABORT, dtfb_pkg::OP_WR_CMP, dtfb_pkg::OP_WR_ALL,
			dtfb_pkg::OP_READ: begin
			end
			default: begin
				res_run.status = dtfb_pkg::STATUS_INVALID_ARG;
			end
		endcase
		if (adv_en) begin
			if (adv_done) begin
				res_run.flush_done = 1'b1;
			end else begin
				res_run.window_valid  = 1'b1;
				res_run.window_left   = src_left[EW-1:0];
				res_run.window_top    = src_row[EW-1:0];
				res_run.window_right  = src_right[EW-1:0];
				res_run.window_bottom = row_nxt[EW-1:0];
				res_run.buffer_select = src_buf;
			end
		end
		res_run.commit_count = (adv_en && adv_done)
			? commit_q + dtfb_pkg::COUNT_W'(1) : commit_q;
	end

	always_comb begin
		res_mem              = '0;
		res_mem.read_color   = (op_s1 == dtfb_pkg::OP_READ) ? rd_data_q : '0;
		res_mem.commit_count = commit_q;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1    <= head_item.op;
			x_s1     <= head_item.x;
			y_s1     <= head_item.y;
			color_s1 <= head_item.color;
			addr_s1  <= head_addr;
		end
		if (pop && !is_mem) begin
			res_q <= res_run;
		end else if (state_q == ST_MEM) begin
			res_q <= res_mem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			dirty_valid_q  <= 1'b1;
			dleft_q        <= '0;
			dtop_q         <= '0;
			dright_q       <= CW'(WIDTH);
			dbottom_q      <= CW'(HEIGHT);
			flush_active_q <= 1'b0;
			fleft_q        <= '0;
			fright_q       <= '0;
			frow_q         <= '0;
			fend_q         <= '0;
			stripe_buf_q   <= 1'b0;
			commit_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if ((pop && !is_mem) || (state_q == ST_MEM)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (pop) begin
						if (is_mem) begin
							state_q <= ST_MEM;
						end
						if (head_item.op == dtfb_pkg::OP_ABORT) begin
							flush_active_q <= 1'b0;
						end
						if (adv_en) begin
							fleft_q  <= src_left;
							fright_q <= src_right;
							fend_q   <= src_end;
							if (adv_done) begin
								flush_active_q <= 1'b0;
								dirty_valid_q  <= 1'b0;
								commit_q       <= commit_q + dtfb_pkg::COUNT_W'(1);
							end else begin
								flush_active_q <= 1'b1;
								frow_q         <= row_nxt;
								stripe_buf_q   <= !src_buf;
							end
						end
					end
				end
				ST_MEM: begin
					state_q <= ST_RUN;
					if (wr_hit) begin
						dirty_valid_q <= 1'b1;
						if (!dirty_valid_q) begin
							dleft_q   <= x_s1;
							dtop_q    <= y_s1;
							dright_q  <= x_s1 + CW'(1);
							dbottom_q <= y_s1 + CW'(1);
						end else begin
							if (x_s1 < dleft_q) dleft_q <= x_s1;
							if (y_s1 < dtop_q) dtop_q <= y_s1;
							if (x_s1 + CW'(1) > dright_q) dright_q <= x_s1 + CW'(1);
							if (y_s1 + CW'(1) > dbottom_q) dbottom_q <= y_s1 + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = res_q.status;
	assign rsp.read_color    = res_q.read_color;
	assign rsp.flush_done    = res_q.flush_done;
	assign rsp.window_valid  = res_q.window_valid;
	assign rsp.window_left   = res_q.window_left;
	assign rsp.window_top    = res_q.window_top;
	assign rsp.window_right  = res_q.window_right;
	assign rsp.window_bottom = res_q.window_bottom;
	assign rsp.buffer_select = res_q.buffer_select;
	assign rsp.commit_count  = res_q.commit_count;

endmodule

// ===== rtl/dirty_tracking_frame_buffer_unit.sv =====
// Dirty-tracking frame buffer, top level. A flush, abort or rejected command passes the
// queue and the result register; a pixel read or write also passes the registered store read.
// Pixel commands: the back reads the pixel, compares and writes in the cycle after, and
// takes no new command meanwhile. One flush/abort or rejected command per cycle while the
// queue holds commands and the result channel is free.
// Reset is asynchronous, active low. After reset a clearing pass zeroes the pixel store,
// one pixel a cycle; req.ready stays low meanwhile.
module dirty_tracking_frame_buffer_unit #(
	parameter int WIDTH       = dtfb_pkg::WIDTH_DEF,
	parameter int HEIGHT      = dtfb_pkg::HEIGHT_DEF,
	parameter int STRIPE_ROWS = dtfb_pkg::STRIPE_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dtfb_req_if.sink    req,
	dtfb_rsp_if.source  rsp
);

	// Linear pixel address width, shared by the front, the queue and the back.
	localparam int ADDR_W = $clog2(WIDTH * HEIGHT);
	localparam int ITEM_W = $bits(dtfb_pkg::item_t);
	localparam int QW     = ITEM_W + ADDR_W;

	// Front to queue.
	logic                   push;
	dtfb_pkg::item_t        item;
	logic [ADDR_W-1:0]      addr;
	logic                   queue_full;

	// Queue to back.
	logic                   pop;
	logic                   head_valid;
	logic [QW-1:0]          head_data;
	dtfb_pkg::item_t        head_item;
	logic [ADDR_W-1:0]      head_addr;

	dtfb_pkg::back_status_t stat;

	// The front decodes each command transaction, rejects out-of-range
	// coordinates and unknown commands, and computes the row-major address.
	dtfb_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.req        (req),
		.stat       (stat),
		.queue_full (queue_full),
		.push       (push),
		.item       (item),
		.addr       (addr)
	);

	// The queue lets the front keep taking transactions while the back is in
	// the middle of a read-modify-write or waits on the result channel.
	dtfb_queue #(
		.DATA_W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({item, addr}),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	assign head_item = head_data[QW-1:ADDR_W];
	assign head_addr = head_data[ADDR_W-1:0];

	// The back executes one command at a time. Pixel commands read the store,
	// then compare, write and grow the dirty box in the cycle after, so a
	// following command always sees the updated pixel. Flush commands plan a
	// stripe combinationally. Results sit in an output register, so the back
	// takes the next command in the same cycle the previous result leaves.
	dtfb_back #(
		.WIDTH       (WIDTH),
		.HEIGHT      (HEIGHT),
		.STRIPE_ROWS (STRIPE_ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.head_addr  (head_addr),
		.pop        (pop),
		.stat       (stat),
		.rsp        (rsp)
	);

endmodule
